@@ design/lsf_pkg.sv @@
// Shared types, constants and coefficient functions for the luma sharpening filter.
`timescale 1ns / 1ps

package lsf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int PAIR_W     = SAMPLE_W + 1;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 12;
  localparam int MUL_SPLIT  = 24;   // low slice of the correction for the gain product
  localparam int FIFO_DEPTH = 16;   // power of two
  localparam int Q30_BITS   = 30;
  localparam int TAP_COUNT  = 16;

  localparam logic [SAMPLE_W-1:0]      PIXEL_MAX  = 16'hFFFF;
  localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd4096;

  // Q2.30 magnitudes: centre minus one is positive, side taps are negative
  localparam logic [31:0] CENTRE_Q30 = 32'd71041762;
  localparam logic [31:0] TAP_Q30 [TAP_COUNT] = '{
    32'd29317999, 32'd1409701, 32'd2124991, 32'd1151606,
    32'd248141,   32'd805455,  32'd340,     32'd462648,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
  };

  // Input request and output request payloads
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                end_of_line;
  } lsf_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] pixel;
    logic                line_done;
  } lsf_out_t;

  // Side-band info that travels alongside the arithmetic pipeline
  typedef struct packed {
    logic                valid;
    logic                filt;
    logic                last;
    logic [SAMPLE_W-1:0] samp;
  } lsf_meta_t;

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } lsf_state_t;

  // Round a Q2.30 magnitude half up to frac fraction bits
  function automatic logic [31:0] coef_round(input logic [31:0] mag, input int frac);
    int          s;
    logic [31:0] r;
    s = Q30_BITS - frac;
    if (s <= 0) begin
      r = mag;
    end else begin
      r = (mag + (32'd1 << (s - 1))) >> s;
    end
    return r;
  endfunction

  // Coefficient magnitude of tap t (t = 0 is the centre term)
  function automatic logic [31:0] tap_coef(input int t, input int frac);
    logic [31:0] m;
    if (t == 0) begin
      m = CENTRE_Q30;
    end else if (t <= TAP_COUNT) begin
      m = TAP_Q30[t-1];
    end else begin
      m = '0;
    end
    return coef_round(m, frac);
  endfunction

endpackage

@@ design/lsf_cell.sv @@
// One window cell: holds a sample and passes it to its neighbor on each shift.
`timescale 1ns / 1ps

module lsf_cell import lsf_pkg::*; (
  input  logic                clk,
  input  logic                shift,
  input  logic [SAMPLE_W-1:0] d,
  output logic [SAMPLE_W-1:0] q
);

  // window storage is undefined until written, so no reset
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

@@ design/lsf_tap.sv @@
// Symmetric tap: adds a sample pair and multiplies by a fixed coefficient.
`timescale 1ns / 1ps

module lsf_tap import lsf_pkg::*; #(
  parameter int          COEF_W = 21,
  parameter logic [31:0] COEF   = 32'd1110028
) (
  input  logic                       clk,
  input  logic [SAMPLE_W-1:0]        a,
  input  logic [SAMPLE_W-1:0]        b,
  output logic [COEF_W+PAIR_W-1:0]   prod
);

  localparam logic [COEF_W-1:0] C = COEF[COEF_W-1:0];

  logic [PAIR_W-1:0] pair;

  assign pair = {1'b0, a} + {1'b0, b};

  // registered product, unsigned magnitude
  always_ff @(posedge clk) begin
    prod <= (COEF_W + PAIR_W)'(pair) * (COEF_W + PAIR_W)'(C);
  end

endmodule

@@ design/lsf_post.sv @@
// Correction sum tree, gain product, rounding and clamping pipeline.
`timescale 1ns / 1ps

module lsf_post import lsf_pkg::*; #(
  parameter int RADIUS         = 8,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic signed [GAIN_W-1:0]                gain,
  input  logic [COEF_FRAC_BITS-3+PAIR_W-1:0]      prod [RADIUS+1],
  input  lsf_meta_t                               meta_in,
  output logic                                    res_valid,
  output lsf_out_t                                res
);

  localparam int COEF_W = COEF_FRAC_BITS - 3;
  localparam int PROD_W = COEF_W + PAIR_W;
  localparam int LVLS   = $clog2(RADIUS + 1);
  localparam int LEAVES = 1 << LVLS;
  localparam int CORR_W = PROD_W + LVLS + 1;
  localparam int HI_W   = CORR_W - MUL_SPLIT;
  localparam int PLO_W  = GAIN_W + MUL_SPLIT + 1;
  localparam int PHI_W  = GAIN_W + HI_W;
  localparam int GC_W   = CORR_W + GAIN_W;
  localparam int SH     = GAIN_FRAC + COEF_FRAC_BITS;
  localparam int TOT_W  = GC_W + 1;
  localparam int RND_W  = TOT_W + 1;
  localparam int Q_W    = RND_W - SH;
  localparam int MLEN   = LVLS + 3;
  localparam logic [RND_W-1:0] HALF = RND_W'(1) << (SH - 1);

  logic signed [CORR_W-1:0] leaf [LEAVES];
  logic signed [CORR_W-1:0] lvl  [LVLS][LEAVES/2];
  logic signed [CORR_W-1:0] corr;
  logic [MUL_SPLIT-1:0]     corr_lo;
  logic signed [HI_W-1:0]   corr_hi;
  logic signed [PLO_W-1:0]  p_lo;
  logic signed [PHI_W-1:0]  p_hi;
  logic signed [GC_W-1:0]   gc;
  logic signed [TOT_W-1:0]  cterm;
  logic signed [TOT_W-1:0]  total;
  logic [RND_W-1:0]         rnd;
  logic [Q_W-1:0]           q;
  logic [SAMPLE_W-1:0]      pix;
  lsf_meta_t                mline [MLEN];

  // leaves: centre term positive, side taps negative, padding zero
  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i == 0) begin : g_centre
      assign leaf[i] = CORR_W'(prod[i]);
    end else if (i <= RADIUS) begin : g_side
      assign leaf[i] = -(CORR_W'(prod[i]));
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  // registered adder tree, one level per cycle
  always_ff @(posedge clk) begin
    for (int i = 0; i < LEAVES / 2; i++) begin
      lvl[0][i] <= leaf[2*i] + leaf[2*i+1];
    end
    for (int l = 1; l < LVLS; l++) begin
      for (int i = 0; i < (LEAVES >> (l + 1)); i++) begin
        lvl[l][i] <= lvl[l-1][2*i] + lvl[l-1][2*i+1];
      end
    end
  end

  assign corr    = lvl[LVLS-1][0];
  assign corr_lo = corr[MUL_SPLIT-1:0];
  assign corr_hi = corr[CORR_W-1:MUL_SPLIT];

  // gain product in two slices, then recombined
  always_ff @(posedge clk) begin
    p_lo <= gain * $signed({1'b0, corr_lo});
    p_hi <= gain * corr_hi;
    gc   <= (GC_W'(p_hi) <<< MUL_SPLIT) + GC_W'(p_lo);
    total <= TOT_W'(gc) + cterm;
  end

  assign cterm = $signed(TOT_W'(mline[LVLS+1].samp) << SH);

  // round half up; any negative total clamps to zero
  assign rnd = RND_W'($unsigned(total)) + HALF;
  assign q   = rnd[RND_W-1:SH];

  always_comb begin
    if (total[TOT_W-1]) begin
      pix = '0;
    end else if (|q[Q_W-1:SAMPLE_W]) begin
      pix = PIXEL_MAX;
    end else begin
      pix = q[SAMPLE_W-1:0];
    end
  end

  // side-band line, aligned with the arithmetic stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MLEN; i++) begin
        mline[i].valid <= 1'b0;
      end
      res_valid <= 1'b0;
    end else begin
      mline[0] <= meta_in;
      for (int i = 1; i < MLEN; i++) begin
        mline[i] <= mline[i-1];
      end
      res_valid <= mline[MLEN-1].valid;
    end
  end

  // result register: filtered value or passed-through sample
  always_ff @(posedge clk) begin
    res.pixel     <= mline[MLEN-1].filt ? pix : mline[MLEN-1].samp;
    res.line_done <= mline[MLEN-1].last;
  end

endmodule

@@ design/luma_symmetric_fir_sharpen.sv @@
// Top level of the symmetric 17-tap luma sharpening filter.
`timescale 1ns / 1ps
// Usage:
//   sample_req carries one luma sample and an end-of-line mark; it is taken at a
//   clock edge where sample_valid is high and sample_stall is low. pixel_req
//   carries the output sample and line_done; it is taken where pixel_valid is
//   high and pixel_stall is low. gain_we/gain_wdata write the Q4.12 gain; write
//   it only while no line is in flight.
//   Output j of a line is issued when input j+RADIUS is taken (the first and
//   last RADIUS samples pass through unchanged). The product register loads at
//   the accepting edge; pixel_valid then rises after the registered adder
//   tree, the two-slice gain multiply, recombine, sum, round/clamp into the
//   result register, and the output buffer write.
//   Throughput is one sample per cycle while sample_stall is low. After an
//   end-of-line request the block emits up to RADIUS pending samples, one per
//   cycle while the buffer has room, holding sample_stall high meanwhile.
//   Results wait in a 16-entry buffer; when the receiver stalls, sample_stall
//   rises once 16 results are buffered or in flight.
//   Reset sets gain to 1.0, clears the line position and empties the buffer;
//   sample_stall is high during reset.

module luma_symmetric_fir_sharpen import lsf_pkg::*; #(
  parameter int RADIUS         = 8,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  lsf_in_t             sample_req,
  input  logic                sample_valid,
  output logic                sample_stall,
  output lsf_out_t            pixel_req,
  output logic                pixel_valid,
  input  logic                pixel_stall,
  input  logic                gain_we,
  input  logic [GAIN_W-1:0]   gain_wdata
);

  localparam int WIN    = 2 * RADIUS + 1;
  localparam int NCELL  = 2 * RADIUS;
  localparam int CNT_W  = $clog2(2 * RADIUS + 1);
  localparam int IDX_W  = (RADIUS > 1) ? $clog2(RADIUS) : 1;
  localparam int COEF_W = COEF_FRAC_BITS - 3;
  localparam int PROD_W = COEF_W + PAIR_W;
  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int OCC_W  = $clog2(FIFO_DEPTH + 1);

  logic [SAMPLE_W-1:0]     cell_q [NCELL];
  logic [SAMPLE_W-1:0]     view   [WIN];
  logic [SAMPLE_W-1:0]     pend_q [RADIUS];
  logic [PROD_W-1:0]       prod   [RADIUS+1];
  logic signed [GAIN_W-1:0] gain;
  logic [CNT_W-1:0]        seen;
  logic [IDX_W-1:0]        pend_m1;
  logic                    emit;
  logic                    filt;
  logic                    acc;
  logic                    room;
  logic                    pop;
  lsf_state_t              state;
  lsf_state_t              state_next;
  logic [IDX_W-1:0]        fl_idx;
  logic [IDX_W-1:0]        fl_idx_next;
  lsf_meta_t               inj;
  lsf_meta_t               meta0;
  logic                    res_valid;
  lsf_out_t                res;
  logic [OCC_W-1:0]        occ;
  logic [OCC_W-1:0]        fcnt;
  logic [PTR_W-1:0]        wr_ptr;
  logic [PTR_W-1:0]        rd_ptr;
  lsf_out_t                fifo_mem [FIFO_DEPTH];

  // window cell chain; view is the window after the incoming sample shifts in
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    if (k == 0) begin : g_head
      lsf_cell u_cell (.clk(clk), .shift(acc), .d(sample_req.sample), .q(cell_q[k]));
    end else begin : g_body
      lsf_cell u_cell (.clk(clk), .shift(acc), .d(cell_q[k-1]), .q(cell_q[k]));
    end
  end

  assign view[0] = sample_req.sample;
  for (genvar k = 1; k < WIN; k++) begin : g_view
    assign view[k] = cell_q[k-1];
  end

  for (genvar k = 0; k < RADIUS; k++) begin : g_pend
    assign pend_q[k] = cell_q[k];
  end

  // centre term and symmetric pair taps
  for (genvar t = 0; t <= RADIUS; t++) begin : g_tap
    if (t == 0) begin : g_centre
      lsf_tap #(.COEF_W(COEF_W), .COEF(tap_coef(t, COEF_FRAC_BITS))) u_tap (
        .clk(clk), .a(view[RADIUS]), .b('0), .prod(prod[t])
      );
    end else begin : g_pair
      lsf_tap #(.COEF_W(COEF_W), .COEF(tap_coef(t, COEF_FRAC_BITS))) u_tap (
        .clk(clk), .a(view[RADIUS-t]), .b(view[RADIUS+t]), .prod(prod[t])
      );
    end
  end

  lsf_post #(.RADIUS(RADIUS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_post (
    .clk(clk), .rst(rst), .gain(gain), .prod(prod), .meta_in(meta0),
    .res_valid(res_valid), .res(res)
  );

  // line position decode
  assign emit = seen >= CNT_W'(RADIUS);
  assign filt = seen >= CNT_W'(2 * RADIUS);
  assign pend_m1 = (seen < CNT_W'(RADIUS - 1)) ? IDX_W'(seen) : IDX_W'(RADIUS - 1);

  // accept control; occ counts everything issued but not yet taken
  assign room         = occ != OCC_W'(FIFO_DEPTH);
  assign sample_stall = rst || (state != ST_RUN) || !room;
  assign acc          = sample_valid && !sample_stall;
  assign pop          = pixel_valid && !pixel_stall;

  // next state and pipeline issue
  always_comb begin
    state_next  = state;
    fl_idx_next = fl_idx;
    inj         = '0;
    case (state)
      ST_RUN: begin
        if (acc) begin
          inj.valid = emit;
          inj.filt  = filt;
          inj.samp  = view[RADIUS];
          if (sample_req.end_of_line) begin
            state_next  = ST_FLUSH;
            fl_idx_next = pend_m1;
          end
        end
      end
      ST_FLUSH: begin
        if (room) begin
          inj.valid = 1'b1;
          inj.samp  = pend_q[fl_idx];
          inj.last  = (fl_idx == '0);
          if (fl_idx == '0) begin
            state_next = ST_RUN;
          end else begin
            fl_idx_next = fl_idx - IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_RUN;
      fl_idx <= '0;
    end else begin
      state  <= state_next;
      fl_idx <= fl_idx_next;
    end
  end

  // line position counter, saturating at twice the radius
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (acc) begin
      if (sample_req.end_of_line) begin
        seen <= '0;
      end else if (seen != CNT_W'(2 * RADIUS)) begin
        seen <= seen + CNT_W'(1);
      end
    end
  end

  // gain register
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (gain_we) begin
      gain <= $signed(gain_wdata);
    end
  end

  // issue register, aligned with the tap products
  always_ff @(posedge clk) begin
    if (rst) begin
      meta0.valid <= 1'b0;
    end else begin
      meta0 <= inj;
    end
  end

  // credit count: requests issued into the pipeline and not yet taken
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + OCC_W'(inj.valid) - OCC_W'(pop);
    end
  end

  // output buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fcnt   <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fcnt <= fcnt + OCC_W'(res_valid) - OCC_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      fifo_mem[wr_ptr] <= res;
    end
  end

  assign pixel_valid = fcnt != '0;
  assign pixel_req   = fifo_mem[rd_ptr];

`ifndef ASSERT_OFF
  // buffered results are always covered by the credit count
  a_fifo_within_credit: assert property (@(posedge clk) disable iff (rst)
    fcnt <= occ)
    else $error("output buffer holds more than issued requests");

  // the pipeline never writes into a full buffer
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (fcnt != OCC_W'(FIFO_DEPTH)) || pop)
    else $error("result written into full output buffer");

  // flushing starts only right after an end-of-line request
  a_flush_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH && $past(state) == ST_RUN) |->
      $past(acc && sample_req.end_of_line))
    else $error("flush entered without end of line");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the luma sharpening filter: random stream, predictor, scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import lsf_pkg::*;

  // Filter geometry and fixed point, as the block is built
  localparam int REACH      = 8;
  localparam int TAPS       = 2 * REACH + 1;
  localparam int FRAC_BITS  = 24;
  localparam int COEF_SHIFT = 30 - FRAC_BITS;
  localparam int PROD_SHIFT = GAIN_FRAC + FRAC_BITS;
  localparam int MAX_WAIT   = 14;
  localparam int SETTLE     = 24;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  lsf_in_t           sample_req   = '0;
  logic              sample_valid = 1'b0;
  logic              sample_stall;
  lsf_out_t          pixel_req;
  logic              pixel_valid;
  logic              pixel_stall  = 1'b0;
  logic              gain_we      = 1'b0;
  logic [GAIN_W-1:0] gain_wdata   = '0;

  // Stimulus and scoreboard storage
  lsf_in_t  pending_q[$];
  lsf_out_t pixel_exp_q[$];

  // Predictor state
  logic [SAMPLE_W-1:0]      line_win [TAPS];
  int                       line_pos = 0;
  logic signed [GAIN_W-1:0] gain_now = GAIN_RESET;

  // Handshake bookkeeping
  logic in_taken   = 1'b0;
  logic out_taken  = 1'b0;
  logic send_burst = 1'b0;
  logic recv_burst = 1'b0;
  int   gap_left   = 0;
  int   hold_left  = 0;

  // Run statistics
  int items_queued  = 0;
  int items_taken   = 0;
  int lines_queued  = 0;
  int pixels_seen   = 0;
  int gains_applied = 1;
  int mismatches    = 0;

  luma_symmetric_fir_sharpen u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_req   (sample_req),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .pixel_req    (pixel_req),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .gain_we      (gain_we),
    .gain_wdata   (gain_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    for (int k = 0; k < TAPS; k++) line_win[k] = '0;
  end

  // Kernel magnitudes in Q2.30: centre minus one is positive, side taps negative
  function automatic longint tap_mag(input int t);
    case (t)
      0:       return 71041762;
      1:       return 29317999;
      2:       return 1409701;
      3:       return 2124991;
      4:       return 1151606;
      5:       return 248141;
      6:       return 805455;
      7:       return 340;
      8:       return 462648;
      default: return 0;
    endcase
  endfunction

  // Q2.30 magnitude rounded half up to the coefficient fraction width
  function automatic longint tap_coef(input int t);
    return (tap_mag(t) + (longint'(1) << (COEF_SHIFT - 1))) >>> COEF_SHIFT;
  endfunction

  // Sharpened value of the window centre, rounded away from zero and clamped
  function automatic logic [SAMPLE_W-1:0] sharpened_centre();
    longint centre, pair, corr, g, total, half, q;
    centre = line_win[REACH];
    corr   = tap_coef(0) * centre;
    for (int t = 1; t <= REACH; t++) begin
      pair = line_win[REACH - t];
      pair = pair + line_win[REACH + t];
      corr = corr - tap_coef(t) * pair;
    end
    g     = gain_now;
    half  = longint'(1) << (PROD_SHIFT - 1);
    total = (centre <<< PROD_SHIFT) + g * corr;
    if (total >= 0) begin
      q = (total + half) >>> PROD_SHIFT;
    end else begin
      q = -((-total + half) >>> PROD_SHIFT);
    end
    if (q < 0) q = 0;
    if (q > 65535) q = 65535;
    return q[SAMPLE_W-1:0];
  endfunction

  // Advance the line predictor by one accepted sample, queue the pixels it releases
  task automatic sharpen_sample(input lsf_in_t req);
    int       seen, next_pos, pend;
    lsf_out_t px;
    seen = line_pos;
    for (int k = TAPS - 1; k > 0; k--) line_win[k] = line_win[k-1];
    line_win[0] = req.sample;
    next_pos = (seen + 1 > 2 * REACH) ? 2 * REACH : seen + 1;
    // lagged output: filtered once both sides are full, else passed through
    if (seen >= REACH) begin
      px.pixel     = (seen >= 2 * REACH) ? sharpened_centre() : line_win[REACH];
      px.line_done = 1'b0;
      pixel_exp_q.push_back(px);
    end
    // end of line flushes the pending tail unchanged
    if (req.end_of_line) begin
      pend = (next_pos < REACH) ? next_pos : REACH;
      for (int k = pend; k > 0; k--) begin
        px.pixel     = line_win[k-1];
        px.line_done = (k == 1);
        pixel_exp_q.push_back(px);
      end
      line_pos = 0;
    end else begin
      line_pos = next_pos;
    end
  endtask

  task automatic note_mismatch(input string what, input lsf_out_t want, input lsf_out_t got);
    if (mismatches < 10) begin
      $display("[%0t] %s: expected pixel %0d line_done %0b, got pixel %0d line_done %0b",
               $realtime, what, want.pixel, want.line_done, got.pixel, got.line_done);
    end
    mismatches++;
  endtask

  // Input source: one request per entry of the pending queue, random gap after each
  always @(negedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      gap_left     <= 0;
    end else begin
      if ($urandom_range(0, 39) == 0) send_burst <= !send_burst;
      if (!sample_valid || in_taken) begin
        if (gap_left > 0) begin
          sample_valid <= 1'b0;
          gap_left     <= gap_left - 1;
        end else if (pending_q.size() != 0) begin
          sample_req   <= pending_q.pop_front();
          sample_valid <= 1'b1;
          gap_left     <= send_burst ? 0 : $urandom_range(0, MAX_WAIT);
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Output sink: random stall after each accepted pixel
  always @(negedge clk) begin : pixel_sink
    int w;
    if ($urandom_range(0, 39) == 0) recv_burst <= !recv_burst;
    w = hold_left;
    if (out_taken) w = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (w > 0) begin
      pixel_stall <= 1'b1;
      hold_left   <= w - 1;
    end else begin
      pixel_stall <= 1'b0;
      hold_left   <= 0;
    end
  end

  // Monitor: capture gain writes and input requests, then check output requests
  always @(posedge clk) begin : monitor
    lsf_out_t want;
    if (rst) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      if (gain_we) gain_now = gain_wdata;
      in_taken <= sample_valid && !sample_stall;
      if (sample_valid && !sample_stall) begin
        sharpen_sample(sample_req);
        items_taken++;
      end
      out_taken <= pixel_valid && !pixel_stall;
      if (pixel_valid && !pixel_stall) begin
        pixels_seen++;
        if (pixel_exp_q.size() == 0) begin
          note_mismatch("unexpected output", '0, pixel_req);
        end else begin
          want = pixel_exp_q.pop_front();
          if (pixel_req.pixel !== want.pixel || pixel_req.line_done !== want.line_done) begin
            note_mismatch("output mismatch", want, pixel_req);
          end
        end
      end
    end
  end

  task automatic queue_sample(input logic [SAMPLE_W-1:0] s, input logic eol);
    lsf_in_t r;
    r.sample      = s;
    r.end_of_line = eol;
    pending_q.push_back(r);
    items_queued++;
    if (eol) lines_queued++;
  endtask

  // One random line: mostly long enough to filter, mixing smooth and wild samples
  task automatic queue_random_line(output int len);
    int base, v;
    len  = ($urandom_range(0, 9) < 7) ? $urandom_range(17, 22) : $urandom_range(1, 16);
    base = $urandom_range(0, 65535);
    for (int j = 0; j < len; j++) begin
      if ($urandom_range(0, 1) == 0) begin
        v = $urandom_range(0, 65535);
      end else begin
        v = base + $urandom_range(0, 1200) - 600;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
      end
      queue_sample(v[SAMPLE_W-1:0], j == len - 1);
    end
  endtask

  // Wait for every request taken and every pixel returned, then let the pipe settle
  task automatic wait_drained();
    do @(negedge clk); while (items_taken != items_queued || pixel_exp_q.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_gain(input logic [GAIN_W-1:0] g);
    gain_we    <= 1'b1;
    gain_wdata <= g;
    @(negedge clk);
    gain_we    <= 1'b0;
    gains_applied++;
  endtask

  // Main sequence: reset, directed lines, then random lines under several gains
  initial begin : stimulus
    logic [GAIN_W-1:0] gain_plan [6];
    int                len, phase_items;
    gain_plan[0] = GAIN_RESET;
    gain_plan[1] = 16'h7FFF;
    gain_plan[2] = 16'h8000;
    gain_plan[3] = 16'h0000;
    gain_plan[4] = $urandom_range(0, 65535);
    gain_plan[5] = $urandom_range(0, 8191);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 6; p++) begin
      if (p != 0) write_gain(gain_plan[p]);
      @(posedge clk);
      if (p == 0) begin
        // single-sample line: all pass through
        queue_sample(16'hFFFF, 1'b1);
        // bright spike on black: clamps high at the spike, low right after it
        for (int j = 0; j < 18; j++) begin
          queue_sample((j == REACH) ? 16'hFFFF : 16'h0000, j == 17);
        end
      end
      phase_items = 0;
      while (phase_items < 8) begin
        queue_random_line(len);
        phase_items += len;
      end
      wait_drained();
    end

    mismatches += pixel_exp_q.size();
    $display("Checked %0d output pixels from %0d input samples in %0d lines",
             pixels_seen, items_taken, lines_queued);
    $display("Gain settings exercised: %0d, mismatches: %0d", gains_applied, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("Timeout with %0d pixels still expected", pixel_exp_q.size());
    $display("FAIL");
    $finish;
  end

endmodule
